// ----- design/drwscan_pkg.sv -----
// ----------------------------------------------------------------------------
// drwscan_pkg
// Shared types and constants of the DNA repeat window scanner.
// ----------------------------------------------------------------------------
package drwscan_pkg;

    localparam int BASE_W     = 2;
    localparam int LEN_W      = 5;
    localparam int GAP_W      = 2;
    localparam int CNT_W      = 5;
    localparam int SCORE_W    = 8;
    localparam int POS_W      = 32;
    // span = 2*L + g, with L < 32 and g < 4
    localparam int SPAN_W     = 7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 56;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP            = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_MISMATCHES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_SCORE        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_SCORE     = 3'd5;

    // reset values
    localparam logic [LEN_W-1:0]   RST_MIN_LENGTH         = 5'd10;
    localparam logic [LEN_W-1:0]   RST_MAX_LENGTH         = 5'd20;
    localparam logic [GAP_W-1:0]   RST_MAX_GAP            = 2'd0;
    localparam logic [CNT_W-1:0]   RST_ALLOWED_MISMATCHES = 5'd2;
    localparam logic [SCORE_W-1:0] RST_MISMATCH_SCORE     = 8'd1;

    typedef struct packed {
        logic [LEN_W-1:0]   min_length;
        logic [LEN_W-1:0]   max_length;
        logic [GAP_W-1:0]   max_gap;
        logic [CNT_W-1:0]   allowed_mismatches;
        logic [SCORE_W-1:0] mismatch_score;
    } drwscan_cfg_t;

    // result of the shared window comparator for one (L, g)
    typedef struct packed {
        logic [CNT_W-1:0] pal_mm;
        logic [CNT_W-1:0] inv_mm;
        logic             pal_hit;
        logic             inv_hit;
    } drwscan_cmp_t;

    // one hit, packed in tdata order (lowest field last)
    typedef struct packed {
        logic [CNT_W-1:0] inv_mismatches;
        logic [CNT_W-1:0] pal_mismatches;
        logic             inv_hit;
        logic             pal_hit;
        logic [GAP_W-1:0] gap;
        logic [LEN_W-1:0] window_length;
        logic [POS_W-1:0] start_position;
    } drwscan_hit_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } drwscan_state_t;

endpackage

// ----- design/drwscan_window.sv -----
// ----------------------------------------------------------------------------
// drwscan_window
// Base history shift line and the shared window comparator (one (L, g) a cycle).
// ----------------------------------------------------------------------------
module drwscan_window
    import drwscan_pkg::*;
#(
    parameter int MAX_LEN = 20,
    parameter int MAX_GAP = 2
)
(
    input  logic                clk,
    input  logic                shift_en,
    input  logic [BASE_W-1:0]   base,
    input  logic [LEN_W-1:0]    len,
    input  logic [SPAN_W-1:0]   span,
    input  logic [CNT_W-1:0]    allowed_mismatches,
    input  logic [SCORE_W-1:0]  mismatch_score,
    output drwscan_cmp_t        cmp
);

    localparam int HIST_DEPTH = 2 * MAX_LEN + MAX_GAP;
    localparam int HIST_W     = BASE_W * HIST_DEPTH;
    localparam int SH_W       = $clog2(HIST_W + 1) + 1;

    // entry k holds the base that arrived k items ago
    logic [HIST_W-1:0]   hist_reg;
    logic [HIST_W-1:0]   rev_vec;
    logic [HIST_W-1:0]   first_vec;
    logic [SH_W-1:0]     sh_amt;
    logic [MAX_LEN-1:0]  pal_diff;
    logic [MAX_LEN-1:0]  inv_diff;
    logic [CNT_W-1:0]    pal_cnt;
    logic [CNT_W-1:0]    inv_cnt;
    logic                no_penalty;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            hist_reg <= {hist_reg[HIST_W-BASE_W-1:0], base};
        end
    end

    // oldest base first, so the mirrored first window lines up from bit 0
    always_comb
    begin
        for (int k = 0; k < HIST_DEPTH; k++)
        begin
            rev_vec[BASE_W*k +: BASE_W] = hist_reg[BASE_W*(HIST_DEPTH-1-k) +: BASE_W];
        end
    end

    // first[i] = history[span-1-i] = rev[HIST_DEPTH-span+i]
    assign sh_amt    = SH_W'(BASE_W) * (SH_W'(HIST_DEPTH) - SH_W'(span));
    assign first_vec = rev_vec >> sh_amt;

    always_comb
    begin
        for (int i = 0; i < MAX_LEN; i++)
        begin
            if (i < int'(len))
            begin
                pal_diff[i] = first_vec[BASE_W*i +: BASE_W] != ~hist_reg[BASE_W*i +: BASE_W];
                inv_diff[i] = first_vec[BASE_W*i +: BASE_W] != hist_reg[BASE_W*i +: BASE_W];
            end
            else
            begin
                pal_diff[i] = 1'b0;
                inv_diff[i] = 1'b0;
            end
        end
    end

    assign pal_cnt = CNT_W'($countones(pal_diff));
    assign inv_cnt = CNT_W'($countones(inv_diff));

    // L*match cancels on both sides of every score compare; with a zero
    // penalty all scores tie and both kinds hit
    assign no_penalty  = (mismatch_score == '0);
    assign cmp.pal_mm  = pal_cnt;
    assign cmp.inv_mm  = inv_cnt;
    assign cmp.pal_hit = no_penalty ||
                         ((pal_cnt <= allowed_mismatches) && (pal_cnt <= inv_cnt));
    assign cmp.inv_hit = no_penalty ||
                         ((inv_cnt <= allowed_mismatches) && (inv_cnt <= pal_cnt));

endmodule

// ----- design/drwscan_seq.sv -----
// ----------------------------------------------------------------------------
// drwscan_seq
// Sequencer over (L, g) pairs, base position counter, hit buffer and output stage.
// ----------------------------------------------------------------------------
module drwscan_seq
    import drwscan_pkg::*;
#(
    parameter int MAX_LEN = 20,
    parameter int MAX_GAP = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  drwscan_cfg_t        cfg,
    input  logic                in_accept,
    input  logic                in_eos,
    output logic                ready,
    output logic [LEN_W-1:0]    len,
    output logic [SPAN_W-1:0]   span,
    input  drwscan_cmp_t        cmp,
    output logic                out_valid,
    input  logic                out_ready,
    output drwscan_hit_t        out_hit,
    output logic                out_last
);

    drwscan_state_t     state_reg, state_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   cur_pos_reg, cur_pos_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   hi_reg, hi_next;
    logic [GAP_W-1:0]   gap_reg, gap_next;
    logic [GAP_W-1:0]   gmax_reg, gmax_next;
    logic               pend_valid_reg, pend_valid_next;
    drwscan_hit_t       pend_reg, pend_next;
    logic               m_valid_reg, m_valid_next;
    drwscan_hit_t       m_hit_reg, m_hit_next;
    logic               m_last_reg, m_last_next;

    logic [LEN_W-1:0]   lo;
    logic [LEN_W-1:0]   hi;
    logic [GAP_W-1:0]   gmax;
    logic [POS_W-1:0]   span_m1;
    logic               in_range;
    logic               hit_now;
    logic               out_free;
    drwscan_hit_t       new_hit;

    assign lo   = (cfg.min_length == '0) ? LEN_W'(1) : cfg.min_length;
    assign hi   = (int'(cfg.max_length) > MAX_LEN) ? LEN_W'(MAX_LEN) : cfg.max_length;
    assign gmax = (int'(cfg.max_gap) > MAX_GAP) ? GAP_W'(MAX_GAP) : cfg.max_gap;

    assign len      = len_reg;
    assign span     = SPAN_W'({len_reg, 1'b0}) + SPAN_W'(gap_reg);
    assign span_m1  = POS_W'(span) - POS_W'(1);
    assign in_range = (cur_pos_reg >= span_m1);
    assign hit_now  = in_range && (cmp.pal_hit || cmp.inv_hit);
    assign out_free = !m_valid_reg || out_ready;

    assign new_hit.start_position = cur_pos_reg - span_m1;
    assign new_hit.window_length  = len_reg;
    assign new_hit.gap            = gap_reg;
    assign new_hit.pal_hit        = cmp.pal_hit;
    assign new_hit.inv_hit        = cmp.inv_hit;
    assign new_hit.pal_mismatches = cmp.pal_mm;
    assign new_hit.inv_mismatches = cmp.inv_mm;

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        cur_pos_next    = cur_pos_reg;
        len_next        = len_reg;
        hi_next         = hi_reg;
        gap_next        = gap_reg;
        gmax_next       = gmax_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg;
        m_hit_next      = m_hit_reg;
        m_last_next     = m_last_reg;

        if (m_valid_reg && out_ready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    cur_pos_next = pos_reg;
                    if (in_eos)
                    begin
                        pos_next = '0;
                    end
                    else if (pos_reg != '1)
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                    len_next   = lo;
                    gap_next   = '0;
                    hi_next    = hi;
                    gmax_next  = gmax;
                    state_next = (lo <= hi) ? ST_SCAN : ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                // hold the pair while a hit has nowhere to go
                if (!(hit_now && pend_valid_reg && !out_free))
                begin
                    if (hit_now)
                    begin
                        if (pend_valid_reg)
                        begin
                            m_hit_next   = pend_reg;
                            m_last_next  = 1'b0;
                            m_valid_next = 1'b1;
                        end
                        pend_next       = new_hit;
                        pend_valid_next = 1'b1;
                    end
                    if (gap_reg == gmax_reg)
                    begin
                        if (len_reg == hi_reg)
                        begin
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            len_next = len_reg + LEN_W'(1);
                            gap_next = '0;
                        end
                    end
                    else
                    begin
                        gap_next = gap_reg + GAP_W'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    m_hit_next      = pend_reg;
                    m_last_next     = 1'b1;
                    m_valid_next    = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_pos_reg <= cur_pos_next;
        len_reg     <= len_next;
        hi_reg      <= hi_next;
        gap_reg     <= gap_next;
        gmax_reg    <= gmax_next;
        pend_reg    <= pend_next;
        m_hit_reg   <= m_hit_next;
        m_last_reg  <= m_last_next;
    end

    assign ready     = (state_reg == ST_IDLE);
    assign out_valid = m_valid_reg;
    assign out_hit   = m_hit_reg;
    assign out_last  = m_last_reg;

endmodule

// ----- design/dna_repeat_window_scanner_core.sv -----
// ----------------------------------------------------------------------------
// dna_repeat_window_scanner_core
// Streams DNA bases and reports palindrome / inverted-repeat window hits.
// ----------------------------------------------------------------------------
//
//   channel   direction  transaction                        fields
//   s_*       in         one base                           tdata: base; tlast: end of sequence
//   m_*       out        one hit per matching (L, g)        tdata: hit fields; tlast: last hit
//   cfg_*     in         one register write, no read-back   index 0..5, data 8 bits
//
// Steps for each base: the idle state takes the base, each (L, g) pair then passes
// through the shared comparator in turn, and a flush step releases the final hit;
// the next base is taken only once the scan is back in the idle state.
// Reset clears control state and the base position; the history needs no clear
// because a pair is tested only once all of its bases have arrived.
// A stalled output holds the scan when a new hit finds both the hit buffer and
// the output register full, and holds the final release while that register stays full.
//
module dna_repeat_window_scanner_core
    import drwscan_pkg::*;
#(
    parameter int MAX_LEN = 20,
    parameter int MAX_GAP = 2
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_TDATA_W-1:0]   s_tdata,   // [1:0] base, [7:2] zero
    input  logic                    s_tlast,

    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [31:0] start_position, [36:32] window_length, [38:37] gap, [39] pal_hit,
    // [40] inv_hit, [45:41] pal_mismatches, [50:46] inv_mismatches, [55:51] zero
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    output logic                    m_tlast,

    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int HIT_W = $bits(drwscan_hit_t);

    drwscan_cfg_t       cfg_reg;
    drwscan_cmp_t       cmp;
    drwscan_hit_t       out_hit;
    logic               in_accept;
    logic               seq_ready;
    logic [LEN_W-1:0]   len;
    logic [SPAN_W-1:0]  span;

    // Configuration registers. match_score cancels out of every score
    // comparison, so a write to it has nothing to store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_length         <= RST_MIN_LENGTH;
            cfg_reg.max_length         <= RST_MAX_LENGTH;
            cfg_reg.max_gap            <= RST_MAX_GAP;
            cfg_reg.allowed_mismatches <= RST_ALLOWED_MISMATCHES;
            cfg_reg.mismatch_score     <= RST_MISMATCH_SCORE;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MIN_LENGTH:         cfg_reg.min_length         <= cfg_wdata[LEN_W-1:0];
                CFG_MAX_LENGTH:         cfg_reg.max_length         <= cfg_wdata[LEN_W-1:0];
                CFG_MAX_GAP:            cfg_reg.max_gap            <= cfg_wdata[GAP_W-1:0];
                CFG_ALLOWED_MISMATCHES: cfg_reg.allowed_mismatches <= cfg_wdata[CNT_W-1:0];
                CFG_MISMATCH_SCORE:     cfg_reg.mismatch_score     <= cfg_wdata;
                default:
                begin
                    // match_score and unused indexes: drop the write
                end
            endcase
        end
    end

    assign s_tready  = seq_ready;
    assign in_accept = s_tvalid && seq_ready;

    // history shift line plus the one comparator shared by all (L, g) pairs
    drwscan_window #(
        .MAX_LEN (MAX_LEN),
        .MAX_GAP (MAX_GAP)
    ) u_window (
        .clk                (clk),
        .shift_en           (in_accept),
        .base               (s_tdata[BASE_W-1:0]),
        .len                (len),
        .span               (span),
        .allowed_mismatches (cfg_reg.allowed_mismatches),
        .mismatch_score     (cfg_reg.mismatch_score),
        .cmp                (cmp)
    );

    // walk L ascending, g ascending; hold one hit back to mark the last one
    drwscan_seq #(
        .MAX_LEN (MAX_LEN),
        .MAX_GAP (MAX_GAP)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_accept (in_accept),
        .in_eos    (s_tlast),
        .ready     (seq_ready),
        .len       (len),
        .span      (span),
        .cmp       (cmp),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_hit   (out_hit),
        .out_last  (m_tlast)
    );

    assign m_tdata = {(OUT_TDATA_W-HIT_W)'(0), out_hit};

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DNA repeat window scanner: streams bases, keeps a
// bit-true scan predictor of its own and compares every hit field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import drwscan_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int SCAN_MAX_LEN   = 20;
    localparam int SCAN_MAX_GAP   = 2;
    localparam int HIST_DEPTH     = 2 * SCAN_MAX_LEN + SCAN_MAX_GAP;
    localparam int SETTLE_CYCLES  = 100;
    localparam int RX_HOLD_CYCLES = 600;
    localparam int STALL_LIMIT    = 4000;
    localparam int NUM_PHASES     = 10;

    // register indexes with no register behind them; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic [BASE_W-1:0] BASE_A = 2'd0;
    localparam logic [BASE_W-1:0] BASE_C = 2'd1;
    localparam logic [BASE_W-1:0] BASE_G = 2'd2;
    localparam logic [BASE_W-1:0] BASE_T = 2'd3;

    typedef struct {
        logic [BASE_W-1:0] base;
        logic              eos;
    } base_item_t;

    typedef struct {
        drwscan_hit_t hit;
        logic         last;
    } hit_rec_t;

    // ------------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    wire                    s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    wire                    m_tvalid;
    logic                   m_tready  = 1'b0;
    wire [OUT_TDATA_W-1:0]  m_tdata;
    wire                    m_tlast;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    dna_repeat_window_scanner_core #(
        .MAX_LEN (SCAN_MAX_LEN),
        .MAX_GAP (SCAN_MAX_GAP)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Scan predictor state: register mirror, base history (newest first) and
    // the position of the next base within the current sequence
    // ------------------------------------------------------------------------
    logic [LEN_W-1:0]    min_len_q   = RST_MIN_LENGTH;
    logic [LEN_W-1:0]    max_len_q   = RST_MAX_LENGTH;
    logic [GAP_W-1:0]    max_gap_q   = RST_MAX_GAP;
    logic [CNT_W-1:0]    allowed_q   = RST_ALLOWED_MISMATCHES;
    logic [SCORE_W-1:0]  match_q     = 8'd1;
    logic [SCORE_W-1:0]  mism_q      = RST_MISMATCH_SCORE;
    logic [BASE_W-1:0]   base_hist [HIST_DEPTH];
    logic [POS_W-1:0]    seq_pos     = '0;

    base_item_t   base_queue[$];     // bases waiting for the driver
    hit_rec_t     hit_expected[$];   // predicted hits, oldest first
    int unsigned  queued_items;
    int unsigned  mismatch_count = 0;
    int unsigned  send_idle_pct  = 0;
    int unsigned  recv_idle_pct  = 0;
    logic         rx_hold_req    = 1'b0;
    logic         rx_hold_ack    = 1'b0;
    int unsigned  rx_hold_left   = 0;
    int unsigned  quiet_cycles   = 0;
    base_item_t   next_base;
    drwscan_hit_t seen_hit;
    hit_rec_t     want_hit;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", what, got, want));
    endtask

    // Shift one base into the history, test every (L, g) pair whose windows lie
    // wholly inside the sequence and queue a hit for each pair that scores.
    task automatic scan_base(input logic [BASE_W-1:0] b, input logic eos);
        longint unsigned count;
        int unsigned     lo, hi, gmax, span, pal_mm, inv_mm;
        longint          full, cutoff, sp, si;
        logic [BASE_W-1:0] first_b, second_b;
        bit              ph, ih;
        hit_rec_t        rec;
        hit_rec_t        found[$];
        for (int k = HIST_DEPTH - 1; k > 0; k--)
            base_hist[k] = base_hist[k - 1];
        base_hist[0] = b;
        count = {32'd0, seq_pos} + 64'd1;
        // clamp the length and gap ranges to what the block is built for
        lo   = (min_len_q == '0) ? 32'd1 : 32'(min_len_q);
        hi   = (32'(max_len_q) > SCAN_MAX_LEN) ? SCAN_MAX_LEN : 32'(max_len_q);
        gmax = (32'(max_gap_q) > SCAN_MAX_GAP) ? SCAN_MAX_GAP : 32'(max_gap_q);
        for (int unsigned len = lo; len <= hi; len++)
        begin
            for (int unsigned g = 0; g <= gmax; g++)
            begin
                span = 2 * len + g;
                if (count < span)
                    continue;
                pal_mm = 0;
                inv_mm = 0;
                // pair the first window with the second one read backwards
                for (int unsigned i = 0; i < len; i++)
                begin
                    first_b  = base_hist[span - 1 - i];
                    second_b = base_hist[i];
                    if (first_b != (2'd3 - second_b))
                        pal_mm++;
                    if (first_b != second_b)
                        inv_mm++;
                end
                full   = longint'(len) * longint'(match_q);
                cutoff = full - longint'(allowed_q) * longint'(mism_q);
                sp     = full - longint'(pal_mm) * longint'(mism_q);
                si     = full - longint'(inv_mm) * longint'(mism_q);
                ph = (sp >= cutoff) && (sp >= si);
                ih = (si >= cutoff) && (si >= sp);
                if (!ph && !ih)
                    continue;
                rec.hit.start_position = POS_W'(count - span);
                rec.hit.window_length  = LEN_W'(len);
                rec.hit.gap            = GAP_W'(g);
                rec.hit.pal_hit        = ph;
                rec.hit.inv_hit        = ih;
                rec.hit.pal_mismatches = CNT_W'(pal_mm);
                rec.hit.inv_mismatches = CNT_W'(inv_mm);
                rec.last               = 1'b0;
                found.push_back(rec);
            end
        end
        if (found.size() != 0)
            found[found.size() - 1].last = 1'b1;
        foreach (found[k])
            hit_expected.push_back(found[k]);
        // end of sequence restarts the position and wipes the history
        if (eos)
        begin
            seq_pos = '0;
            foreach (base_hist[k])
                base_hist[k] = '0;
        end
        else if (seq_pos != '1)
        begin
            seq_pos = seq_pos + 1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Register writes: issue one write per clock and update the mirror at once;
    // the block is idle whenever this runs
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_MIN_LENGTH:         min_len_q = value[LEN_W-1:0];
            CFG_MAX_LENGTH:         max_len_q = value[LEN_W-1:0];
            CFG_MAX_GAP:            max_gap_q = value[GAP_W-1:0];
            CFG_ALLOWED_MISMATCHES: allowed_q = value[CNT_W-1:0];
            CFG_MATCH_SCORE:        match_q   = value[SCORE_W-1:0];
            CFG_MISMATCH_SCORE:     mism_q    = value[SCORE_W-1:0];
            default: ;
        endcase
    endtask

    // Write all six registers; random junk above each narrow field must be dropped.
    task automatic load_settings(input int unsigned lo, input int unsigned hi,
                                 input int unsigned gmax, input int unsigned allowed,
                                 input int unsigned match, input int unsigned mism);
        write_reg(CFG_MIN_LENGTH,
                  (CFG_DATA_W'($urandom) << LEN_W) | CFG_DATA_W'(lo));
        write_reg(CFG_MAX_LENGTH,
                  (CFG_DATA_W'($urandom) << LEN_W) | CFG_DATA_W'(hi));
        write_reg(CFG_MAX_GAP,
                  (CFG_DATA_W'($urandom) << GAP_W) | CFG_DATA_W'(gmax));
        write_reg(CFG_ALLOWED_MISMATCHES,
                  (CFG_DATA_W'($urandom) << CNT_W) | CFG_DATA_W'(allowed));
        write_reg(CFG_MATCH_SCORE, CFG_DATA_W'(match));
        write_reg(CFG_MISMATCH_SCORE, CFG_DATA_W'(mism));
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    task automatic queue_base(input logic [BASE_W-1:0] b, input logic eos);
        base_item_t item;
        item.base = b;
        item.eos  = eos;
        base_queue.push_back(item);
        queued_items++;
    endtask

    task automatic queue_noise(input int unsigned n);
        repeat (n)
            queue_base(BASE_W'($urandom), $urandom_range(0, 11) == 0);
    endtask

    // Build one sequence around a window and its mirror (complemented for a
    // palindrome, plain for an inverted repeat), with a few flipped bases, and
    // hand it over in one go so the driver never sees it half built.
    task automatic queue_repeat(input int unsigned wlen, input int unsigned gsz,
                                input bit mirror_comp, input int unsigned flips);
        base_item_t        seq[$];
        base_item_t        item;
        logic [BASE_W-1:0] win[$];
        item.eos = 1'b0;
        repeat ($urandom_range(0, 3))
        begin
            item.base = BASE_W'($urandom);
            seq.push_back(item);
        end
        for (int unsigned i = 0; i < wlen; i++)
        begin
            item.base = BASE_W'($urandom);
            win.push_back(item.base);
            seq.push_back(item);
        end
        repeat (gsz)
        begin
            item.base = BASE_W'($urandom);
            seq.push_back(item);
        end
        for (int i = int'(wlen) - 1; i >= 0; i--)
        begin
            item.base = mirror_comp ? (2'd3 - win[i]) : win[i];
            if ($urandom_range(0, wlen - 1) < flips)
                item.base = BASE_W'($urandom);
            seq.push_back(item);
        end
        repeat ($urandom_range(0, 2))
        begin
            item.base = BASE_W'($urandom);
            seq.push_back(item);
        end
        // most sequences end here; the rest run on into the next one
        if ($urandom_range(0, 3) != 0)
            seq[seq.size() - 1].eos = 1'b1;
        foreach (seq[k])
            base_queue.push_back(seq[k]);
        queued_items += seq.size();
    endtask

    // Hold the sender until every base is taken and every hit has come, then
    // give the block time to finish a base that causes no hit.
    task automatic wait_drained();
        while (base_queue.size() != 0 || s_tvalid || hit_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: predict on each accepted base, then offer the next one or idle.
    // Valid is only dropped when no transaction is pending.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                scan_base(s_tdata[BASE_W-1:0], s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (base_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_base = base_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_TDATA_W'(next_base.base);
                    s_tlast  <= next_base.eos;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure, plus a long hold-off on request that
    // lets the hit path fill up and stall the input
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            rx_hold_left <= 0;
            rx_hold_ack  <= 1'b0;
        end
        else if (rx_hold_left != 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
            m_tready     <= 1'b0;
        end
        else if (rx_hold_req && !rx_hold_ack)
        begin
            rx_hold_left <= RX_HOLD_CYCLES;
            rx_hold_ack  <= 1'b1;
            m_tready     <= 1'b0;
        end
        else
        begin
            if (!rx_hold_req)
                rx_hold_ack <= 1'b0;
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each accepted hit with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_hit = m_tdata[$bits(drwscan_hit_t)-1:0];
            if (hit_expected.size() == 0)
            begin
                report_mismatch($sformatf("hit with none expected, tdata %h", m_tdata));
            end
            else
            begin
                want_hit = hit_expected.pop_front();
                check_field("start_position", 32'(seen_hit.start_position),
                            32'(want_hit.hit.start_position));
                check_field("window_length", 32'(seen_hit.window_length),
                            32'(want_hit.hit.window_length));
                check_field("gap", 32'(seen_hit.gap), 32'(want_hit.hit.gap));
                check_field("pal_hit", 32'(seen_hit.pal_hit), 32'(want_hit.hit.pal_hit));
                check_field("inv_hit", 32'(seen_hit.inv_hit), 32'(want_hit.hit.inv_hit));
                check_field("pal_mismatches", 32'(seen_hit.pal_mismatches),
                            32'(want_hit.hit.pal_mismatches));
                check_field("inv_mismatches", 32'(seen_hit.inv_mismatches),
                            32'(want_hit.hit.inv_mismatches));
                check_field("tdata padding",
                            32'(m_tdata[OUT_TDATA_W-1:$bits(drwscan_hit_t)]), 32'd0);
                check_field("tlast", 32'(m_tlast), 32'(want_hit.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when nothing moves on any port for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("dna_repeat_window_scanner_core regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned set_lo, set_hi, set_gap, set_allowed, set_match, set_mism;
        int unsigned lo_eff, hi_eff, g_eff, budget, wlen;
        foreach (base_hist[k])
            base_hist[k] = '0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        // sender idles often, receiver idles more
        send_idle_pct = 38;
        recv_idle_pct = 66;

        // reset settings: a clean 10-base palindrome must hit at length 10
        queue_repeat(10, 0, 1'b1, 0);
        wait_drained();

        // range extremes: zero minimum, oversized maximum and gap, no slack,
        // full scores; covers partial windows and a one-base sequence
        load_settings(0, 31, 3, 0, 255, 255);
        queue_base(BASE_A, 1'b0);
        queue_base(BASE_T, 1'b0);
        queue_base(BASE_A, 1'b0);
        queue_base(BASE_A, 1'b0);
        queue_base(BASE_C, 1'b0);
        queue_base(BASE_G, 1'b0);
        queue_base(BASE_G, 1'b0);
        queue_base(BASE_C, 1'b0);
        queue_base(BASE_T, 1'b0);
        queue_base(BASE_A, 1'b1);
        queue_base(BASE_G, 1'b1);
        queue_base(BASE_C, 1'b0);
        queue_base(BASE_G, 1'b1);
        wait_drained();

        // zero scores and full slack: every pair ties, so both flags are set
        load_settings(1, 2, 0, 20, 0, 0);
        queue_base(BASE_T, 1'b0);
        queue_base(BASE_T, 1'b0);
        queue_base(BASE_T, 1'b0);
        queue_base(BASE_T, 1'b1);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // swap the idling sides, then run flat out for the last phases
            if (p == 4)
            begin
                send_idle_pct = 66;
                recv_idle_pct = 38;
            end
            if (p == 7)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            set_lo      = $urandom_range(0, 4);
            set_hi      = set_lo + $urandom_range(0, 4);
            set_gap     = $urandom_range(0, 3);
            set_allowed = ($urandom_range(0, 5) == 0) ? 20 : $urandom_range(0, 4);
            set_match   = $urandom_range(0, 255);
            set_mism    = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 255);
            if ($urandom_range(0, 7) == 0)
                set_hi = 31;
            budget = 32;
            case (p)
                0:
                begin
                    // unmapped indexes must leave every register alone
                    write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
                    write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
                end
                1:
                begin
                    // short windows, every gap, full slack: many hits per base
                    set_lo      = 1;
                    set_hi      = 6;
                    set_gap     = 2;
                    set_allowed = 20;
                end
                2:
                begin
                    // longest window only, with every gap
                    set_lo  = 20;
                    set_hi  = 20;
                    set_gap = 2;
                    budget  = 72;
                end
                4:
                begin
                    // minimum above maximum: nothing may come out
                    set_lo = 15;
                    set_hi = 4;
                    budget = 12;
                end
                6:
                begin
                    // widest scan: every length and every gap
                    set_lo  = 1;
                    set_hi  = 31;
                    set_gap = 2;
                end
                default: ;
            endcase
            load_settings(set_lo, set_hi, set_gap, set_allowed, set_match, set_mism);

            // long receiver hold-off while the sender keeps offering bases
            if (p == 1)
            begin
                rx_hold_req = 1'b1;
                while (!rx_hold_ack)
                    @(posedge clk);
                rx_hold_req = 1'b0;
            end

            lo_eff = (min_len_q == '0) ? 32'd1 : 32'(min_len_q);
            hi_eff = (32'(max_len_q) > SCAN_MAX_LEN) ? SCAN_MAX_LEN : 32'(max_len_q);
            g_eff  = (32'(max_gap_q) > SCAN_MAX_GAP) ? SCAN_MAX_GAP : 32'(max_gap_q);
            queued_items = 0;
            while (queued_items < budget)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    wlen = (lo_eff <= hi_eff) ? $urandom_range(lo_eff, hi_eff)
                                              : $urandom_range(1, 6);
                    queue_repeat(wlen, $urandom_range(0, g_eff), $urandom_range(0, 1),
                                 $urandom_range(0, 2));
                end
                else
                begin
                    queue_noise($urandom_range(1, 8));
                end
            end
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("dna_repeat_window_scanner_core regression: pass");
        else
            $display("dna_repeat_window_scanner_core regression: fail");
        $finish;
    end

endmodule
